FILE: rtl/mpdd_pkg.sv
// Shared types and constants for the Morse press digit decoder.
// No dependencies; imported by every module of the block.
package mpdd_pkg;

    localparam int CNT_W = 16;                       // press tick counter width
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [15:0] DASH_TICKS_RST = 16'd2000;
    localparam logic [7:0]  REL_MARK       = 8'h80;
    localparam logic [7:0]  DASH_MARK      = 8'h60;
    localparam logic [3:0]  BAD_DIGIT      = 4'he;
    localparam logic [2:0]  SYMBOLS        = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_DONE    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [2:0] symbol_count;
        logic [3:0] digit_code;
        logic       entry_done;
        logic [7:0] led_drive;
    } t_result;

endpackage

FILE: rtl/mpdd_digit_dec.sv
// Maps five collected Morse symbols (bit k set = symbol k is a dash) to a digit.
// Depends on mpdd_pkg.
module mpdd_digit_dec
    import mpdd_pkg::*;
(
    input  logic [4:0] i_symbols,
    output logic [3:0] o_digit
);

    // Bit 0 is the first symbol, so dots-then-dashes reads as high ones.
    always_comb begin
        unique case (i_symbols)
            5'b11110: o_digit = 4'd1;
            5'b11100: o_digit = 4'd2;
            5'b11000: o_digit = 4'd3;
            5'b10000: o_digit = 4'd4;
            5'b00000: o_digit = 4'd5;
            5'b00001: o_digit = 4'd6;
            5'b00011: o_digit = 4'd7;
            5'b00111: o_digit = 4'd8;
            5'b01111: o_digit = 4'd9;
            5'b11111: o_digit = 4'd0;
            default:  o_digit = BAD_DIGIT;
        endcase
    end

endmodule

FILE: rtl/mpdd_core.sv
// Entry state, press tick counter and symbol capture of the Morse digit decoder.
// Depends on mpdd_pkg and mpdd_digit_dec.
module mpdd_core
    import mpdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic        i_cmd,
    input  logic        i_level,
    input  logic [15:0] i_long_ticks,
    output t_result     o_result
);

    t_mode            r_mode,  n_mode;
    logic             r_prev,  n_prev;
    logic             r_seen,  n_seen;
    logic [CNT_W-1:0] r_ticks, n_ticks;
    logic [4:0]       r_bits,  n_bits;
    logic [2:0]       r_cursor, n_cursor;
    logic [7:0]       r_fb,    n_fb;
    logic [3:0]       r_digit, n_digit;

    logic [CNT_W-1:0] ticks_inc;
    logic             press, release_ev;
    logic [3:0]       dec_digit;

    assign ticks_inc  = (r_ticks == CNT_MAX) ? r_ticks : r_ticks + 1'b1;
    assign press      = !i_level && r_prev && (r_mode == MODE_COLLECT);
    assign release_ev = i_level && !r_prev && (r_mode == MODE_COLLECT) && r_seen;

    always_comb begin
        n_mode   = r_mode;
        n_prev   = r_prev;
        n_seen   = r_seen;
        n_ticks  = r_ticks;
        n_bits   = r_bits;
        n_cursor = r_cursor;
        n_fb     = r_fb;
        if (i_fire) begin
            if (i_cmd) begin
                n_mode   = MODE_COLLECT;
                n_bits   = '0;
                n_cursor = '0;
                n_fb     = '0;
            end else begin
                n_ticks = ticks_inc;
                n_prev  = i_level;
                if (press) begin
                    n_fb    = 8'd1 << r_cursor;
                    n_seen  = 1'b1;
                    n_ticks = '0;
                end
                if (release_ev) begin
                    n_fb = r_fb | REL_MARK;
                    if (ticks_inc >= CNT_W'(i_long_ticks)) begin
                        n_fb = r_fb | REL_MARK | DASH_MARK;
                        if (r_cursor < SYMBOLS) begin
                            n_bits = r_bits | (5'd1 << r_cursor);
                        end
                    end
                    n_cursor = r_cursor + 3'd1;
                    if (n_cursor >= SYMBOLS) begin
                        n_mode = MODE_DONE;
                    end
                end
            end
        end
    end

    mpdd_digit_dec u_dec (
        .i_symbols (n_bits),
        .o_digit   (dec_digit)
    );

    // decode only on the release that completes the entry
    assign n_digit = (i_fire && !i_cmd && release_ev && n_mode == MODE_DONE) ?
                     dec_digit : r_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_prev   <= 1'b0;
            r_seen   <= 1'b0;
            r_ticks  <= '0;
            r_bits   <= '0;
            r_cursor <= '0;
            r_fb     <= '0;
            r_digit  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_prev   <= n_prev;
            r_seen   <= n_seen;
            r_ticks  <= n_ticks;
            r_bits   <= n_bits;
            r_cursor <= n_cursor;
            r_fb     <= n_fb;
            r_digit  <= n_digit;
        end
    end

    assign o_result.led_drive    = ~n_fb;
    assign o_result.entry_done   = (n_mode == MODE_DONE);
    assign o_result.digit_code   = n_digit;
    assign o_result.symbol_count = n_cursor;

`ifndef SYNTHESIS
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DONE) |-> (r_cursor == SYMBOLS))
        else $error("entry done without five symbols");
    a_collect_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_DONE) |-> (r_cursor < SYMBOLS))
        else $error("cursor past the last symbol while collecting");
    a_press_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_cmd && press) |=> (r_ticks == '0) && r_seen)
        else $error("press did not restart the tick counter");
`endif

endmodule

FILE: rtl/morse_press_digit_decoder_top.sv
// Top level of the Morse press digit decoder: stream ports, input and result registers.
// Depends on mpdd_pkg and mpdd_core.
//
// One word in gives one word out. A word is taken every cycle while the result
// side keeps up; a word waits in the input register until the result side can
// take it, and then its result is loaded into the result register at the same
// edge that raises o_m_axis_tvalid. The whole update of the entry state is
// a single counter increment, a compare against long_press_ticks and a small
// decode table between those two registers. Write long_press_ticks only while
// no word is in flight.
module morse_press_digit_decoder_top
    import mpdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] sensor_level, [7:1] zero
    input  logic        i_s_axis_tuser,   // [0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] led_drive, [8] entry_done,
                                          // [12:9] digit_code, [15:13] symbol_count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data        // long_press_ticks
);

    logic        r_in_valid;
    logic        r_cmd;
    logic        r_level;
    logic        r_out_valid;
    t_result     r_result;
    logic [15:0] r_long_ticks;

    logic    out_load;
    logic    fire;
    t_result core_res;

    assign out_load        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_load;
    assign o_s_axis_tready = !r_in_valid || out_load;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_long_ticks <= DASH_TICKS_RST;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid) begin
                r_long_ticks <= i_cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_cmd   <= i_s_axis_tuser;
            r_level <= i_s_axis_tdata[0];
        end
        if (fire) begin
            r_result <= core_res;
        end
    end

    mpdd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_cmd        (r_cmd),
        .i_level      (r_level),
        .i_long_ticks (r_long_ticks),
        .o_result     (core_res)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

`ifndef SYNTHESIS
    a_done_means_five: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[8]) |-> (o_m_axis_tdata[15:13] == SYMBOLS))
        else $error("entry_done without five symbols");
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[12:9] <= 4'd9 ||
                             o_m_axis_tdata[12:9] == BAD_DIGIT))
        else $error("digit code out of range");
    a_result_follows_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_axis_tvalid)
        else $error("processed word gave no result");
`endif

endmodule

FILE: tb/morse_entry_checker.sv
`timescale 1ns / 1ps
// Result checker for the Morse press digit decoder: follows every accepted word,
// keeps its own copy of the entry state and compares each result word field by field.
// Depends on mpdd_pkg.
module morse_entry_checker
    import mpdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [7:0]  i_s_data,       // [0] sensor_level, [7:1] zero
    input  logic        i_s_user,       // [0] cmd
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [15:0] i_m_data,       // [7:0] led_drive, [8] entry_done,
                                        // [12:9] digit_code, [15:13] symbol_count
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,     // long_press_ticks
    output int          o_mismatches,
    output int          o_outstanding
);

    t_mode            mode;
    logic             last_level;
    logic             pressed_once;
    logic [CNT_W-1:0] held_ticks;
    logic [4:0]       dash_bits;
    logic [2:0]       symbol_pos;
    logic [7:0]       led_pattern;
    logic [3:0]       digit_q;
    logic [15:0]      dash_ticks;
    t_result          expected_words[$];
    int               mismatches = 0;

    // Leading run of equal symbols, then the opposite symbol to the end.
    function automatic logic [3:0] morse_digit(input logic [4:0] dashes);
        logic lead;
        int   run;
        int   d;
        lead = dashes[0];
        run  = 1;
        while (run < SYMBOLS && dashes[run] == lead)
            run++;
        for (int k = run + 1; k < SYMBOLS; k++)
            if (dashes[k] == lead)
                return BAD_DIGIT;
        if (!lead)
            return run[3:0];
        d = 5 + run;
        return (d == 10) ? 4'd0 : d[3:0];
    endfunction

    task automatic take_word(input logic cmd, input logic level);
        t_result r;
        if (cmd) begin
            mode        = MODE_COLLECT;
            dash_bits   = '0;
            symbol_pos  = '0;
            led_pattern = '0;
        end else begin
            if (held_ticks != CNT_MAX)
                held_ticks++;
            if (!level && last_level && mode == MODE_COLLECT) begin
                led_pattern  = 8'd1 << symbol_pos;
                pressed_once = 1'b1;
                held_ticks   = '0;
            end
            // a release only counts once some press has ever been seen
            if (level && !last_level && mode == MODE_COLLECT && pressed_once) begin
                led_pattern |= REL_MARK;
                if (held_ticks >= dash_ticks) begin
                    led_pattern |= DASH_MARK;
                    if (symbol_pos < SYMBOLS)
                        dash_bits[symbol_pos] = 1'b1;
                end
                symbol_pos++;
                if (symbol_pos >= SYMBOLS) begin
                    mode    = MODE_DONE;
                    digit_q = morse_digit(dash_bits);
                end
            end
            last_level = level;
        end
        r.led_drive    = ~led_pattern;
        r.entry_done   = (mode == MODE_DONE);
        r.digit_code   = digit_q;
        r.symbol_count = symbol_pos;
        expected_words.push_back(r);
    endtask

    task automatic note_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    task automatic check_word(input t_result got);
        t_result want;
        if (expected_words.size() == 0) begin
            note_field("word with nothing pending", 'x, got);
            return;
        end
        want = expected_words.pop_front();
        if (got.led_drive !== want.led_drive)
            note_field("led_drive", 16'(want.led_drive), 16'(got.led_drive));
        if (got.entry_done !== want.entry_done)
            note_field("entry_done", 16'(want.entry_done), 16'(got.entry_done));
        if (got.digit_code !== want.digit_code)
            note_field("digit_code", 16'(want.digit_code), 16'(got.digit_code));
        if (got.symbol_count !== want.symbol_count)
            note_field("symbol_count", 16'(want.symbol_count), 16'(got.symbol_count));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode         = MODE_IDLE;
            last_level   = 1'b0;
            pressed_once = 1'b0;
            held_ticks   = '0;
            dash_bits    = '0;
            symbol_pos   = '0;
            led_pattern  = '0;
            digit_q      = '0;
            dash_ticks   = DASH_TICKS_RST;
            expected_words.delete();
        end else begin
            if (i_m_valid && i_m_ready)
                check_word(t_result'(i_m_data));
            if (i_cfg_valid && i_cfg_ready)
                dash_ticks = i_cfg_data;
            if (i_s_valid && i_s_ready)
                take_word(i_s_user, i_s_data[0]);
        end
        o_outstanding <= expected_words.size();
        o_mismatches  <= mismatches;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the Morse press digit decoder testbench: clock, reset, key stimulus,
// threshold writes and verdict. Depends on mpdd_pkg, the block and morse_entry_checker.
module testbench;
    import mpdd_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int QUIET_FROM  = 1550;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;       // [0] sensor_level, [7:1] zero
    logic        s_user;       // [0] cmd
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_data;       // [7:0] led_drive, [8] entry_done, [12:9] digit_code,
                               // [15:13] symbol_count
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;     // long_press_ticks

    int mismatches;
    int outstanding;
    int words_in = 0;
    int words_out = 0;
    int quiet_cycles;
    int dash_ticks;
    bit idling;
    bit sender_gaps;

    morse_press_digit_decoder_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    morse_entry_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_valid     (s_valid),
        .i_s_ready     (s_ready),
        .i_s_data      (s_data),
        .i_s_user      (s_user),
        .i_m_valid     (m_valid),
        .i_m_ready     (m_ready),
        .i_m_data      (m_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        if (m_valid && m_ready)
            words_out <= words_out + 1;

    // watchdog: cycles in a row with no word moving on any channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // result side: short random stalls, plus a long hold-off now and then
    initial begin
        int next_hold;
        next_hold = 300;
        m_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (idling && words_out >= next_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                next_hold = words_out + 900;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end else begin
                m_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    task automatic send_word(input logic cmd, input logic level);
        if (idling && sender_gaps && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {7'd0, level};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
        words_in++;
    endtask

    // threshold only changes once every result is back
    task automatic set_dash_ticks(input logic [15:0] value);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        dash_ticks = int'(value);
    endtask

    task automatic key_symbol(input int held);
        repeat ($urandom_range(1, 3)) send_word(1'b0, 1'b1);
        repeat (held) send_word(1'b0, 1'b0);
    endtask

    // shaped entries follow a valid digit pattern; others press at random lengths
    task automatic enter_digit(input int symbols, input bit shaped);
        logic lead;
        int   run;
        bit   dash;
        int   held;
        lead = 1'($urandom_range(0, 1));
        run  = $urandom_range(1, 5);
        send_word(1'b1, 1'($urandom_range(0, 1)));
        for (int k = 0; k < symbols; k++) begin
            if (shaped) begin
                dash = ((k < run) == lead);
                if (dash)
                    held = dash_ticks + $urandom_range(0, 2);
                else
                    held = $urandom_range(1, dash_ticks > 1 ? dash_ticks - 1 : 1);
            end else begin
                case ($urandom_range(0, 3))
                    0:       held = dash_ticks - 1;
                    1:       held = dash_ticks;
                    default: held = $urandom_range(1, 2 * dash_ticks + 1);
                endcase
            end
            if (held < 1)
                held = 1;
            key_symbol(held);
        end
        repeat ($urandom_range(1, 3)) send_word(1'b0, 1'b1);
    endtask

    initial begin
        int phase;
        rst_n       = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        s_user      = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        idling      = 1'b0;
        sender_gaps = 1'b0;
        dash_ticks  = int'(DASH_TICKS_RST);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idling      = 1'b1;
        sender_gaps = 1'b1;
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b1);      // release while idle
        send_word(1'b0, 1'b0);      // press while idle
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);      // release before any press was seen
        repeat (5) begin
            send_word(1'b0, 1'b0);
            send_word(1'b0, 1'b1);
        end
        send_word(1'b0, 1'b0);      // edges once the entry is done
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b1);

        // zero threshold: every symbol a dash
        set_dash_ticks(16'd0);
        enter_digit(5, 1'b0);

        phase = 0;
        while (words_in < ITEM_TARGET) begin
            set_dash_ticks(16'(phase % 7 == 6 ? $urandom_range(1, 16) : 1 << (phase % 5)));
            idling = (words_in < QUIET_FROM) && (phase < 6 || $urandom_range(0, 3) != 0);
            repeat (5) begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 7))
                    0:       repeat ($urandom_range(6, 20))
                                 send_word($urandom_range(0, 9) == 0,
                                           1'($urandom_range(0, 1)));
                    1:       enter_digit($urandom_range(0, 4), 1'b0);
                    2, 3, 4: enter_digit(5, 1'b1);
                    default: enter_digit(5, 1'b0);
                endcase
            end
            phase++;
        end

        // top threshold: long presses still short of it read as dots
        idling = 1'b0;
        set_dash_ticks(16'hffff);
        send_word(1'b1, 1'b0);
        repeat (5) begin
            send_word(1'b0, 1'b1);
            repeat (20) send_word(1'b0, 1'b0);
        end
        send_word(1'b0, 1'b1);

        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
